[rtl/bpa_pkg.sv]
package bpa_pkg;

    localparam int PAGE_SLOTS  = 4096;
    localparam int ORDER_LIMIT = 13;
    localparam int SLOT_W      = $clog2(PAGE_SLOTS);
    localparam int LINK_W      = SLOT_W + 1;
    localparam int ORD_W       = 4;
    localparam int CNT_W       = 13;
    localparam int CUR_W       = 14;

    // list end marker: one past the last slot
    localparam logic [LINK_W-1:0] NONE_SLOT = LINK_W'(PAGE_SLOTS);

    localparam logic [1:0] REQ_INIT  = 2'd0;
    localparam logic [1:0] REQ_ALLOC = 2'd1;
    localparam logic [1:0] REQ_FREE  = 2'd2;
    localparam logic [1:0] REQ_BAD   = 2'd3;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [11:0] page_index;
        logic [12:0] page_count;
    } req_t;

    typedef struct packed {
        logic        ok;
        logic [11:0] block_index;
        logic [3:0]  block_order;
        logic [12:0] free_total;
    } result_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LATCH,
        OP_CLR_START,
        OP_CLR_STEP,
        OP_CARVE_PUSH,
        OP_PUSH2,
        OP_FREE_RD,
        OP_FREE_SKIP,
        OP_FREE_PUSH,
        OP_BUD_RD,
        OP_UNL_RD_BUD,
        OP_UNL_RD_BLK,
        OP_UNLINK_WR,
        OP_MERGE_PUSH,
        OP_ALLOC_TAKE,
        OP_SPLIT_PUSH,
        OP_ALLOC_FIN,
        OP_FAIL
    } dp_op_t;

    typedef struct packed {
        logic idx_in_range;
        logic mark_set;
        logic bud_avail;
        logic bud_match;
        logic alloc_ok;
        logic split_more;
        logic cnt_zero;
        logic remain_zero;
        logic clr_last;
    } dp_status_t;

endpackage

[rtl/bpa_ram.sv]
module bpa_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/bpa_datapath.sv]
module bpa_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  bpa_pkg::dp_op_t     op,
    input  bpa_pkg::req_t       req,
    input  logic                cfg_we,
    input  logic [12:0]         cfg_wdata,
    output bpa_pkg::dp_status_t status,
    output bpa_pkg::result_t    result
);

    localparam int SW = bpa_pkg::SLOT_W;
    localparam int LW = bpa_pkg::LINK_W;
    localparam int OW = bpa_pkg::ORD_W;
    localparam int CW = bpa_pkg::CNT_W;
    localparam int MO = bpa_pkg::ORDER_LIMIT;

    // control state
    logic [CW-1:0] managed_reg;
    logic [SW-1:0] clr_addr_reg;
    logic [LW-1:0] top_reg [MO];
    logic [CW-1:0] total_reg;

    // working registers
    logic [bpa_pkg::CUR_W-1:0] idx_reg;
    logic [CW-1:0] cnt_reg;
    logic [SW-1:0] blk_reg;
    logic [SW-1:0] uidx_reg;
    logic [SW-1:0] pidx_reg;
    logic [OW-1:0] ord_reg;
    logic [OW-1:0] need_reg;
    logic [LW-1:0] old_reg;
    logic [CW-1:0] pos_reg;
    logic [CW-1:0] remain_reg;
    logic          ok_reg;
    logic [SW-1:0] bidx_reg;
    logic [OW-1:0] bord_reg;

    logic [CW-1:0] range_end;
    logic [CW-1:0] bud_wide;
    logic [SW-1:0] bud;
    logic [OW-1:0] need_c;
    logic [OW-1:0] found;
    logic          hit;
    logic [LW-1:0] found_top;
    logic [OW-1:0] carve_ord;

    logic          push_active;
    logic [SW-1:0] push_idx;
    logic [OW-1:0] push_ord;
    logic [CW-1:0] push_size;
    logic [LW-1:0] top_push;
    logic [CW-1:0] ord_size;

    logic          mark_q;
    logic [OW-1:0] order_q;
    logic [LW-1:0] next_q;
    logic [LW-1:0] prev_q;
    logic          p_valid;
    logic          n_valid;

    logic          mark_we;
    logic [SW-1:0] mark_waddr;
    logic          mark_wdata;
    logic [SW-1:0] mark_raddr;
    logic          order_we;
    logic [SW-1:0] order_waddr;
    logic [OW-1:0] order_wdata;
    logic          next_we;
    logic [SW-1:0] next_waddr;
    logic [LW-1:0] next_wdata;
    logic          prev_we;
    logic [SW-1:0] prev_waddr;
    logic [LW-1:0] prev_wdata;
    logic [SW-1:0] link_raddr;

    assign range_end = (managed_reg > CW'(bpa_pkg::PAGE_SLOTS)) ?
                       CW'(bpa_pkg::PAGE_SLOTS) : managed_reg;
    assign bud_wide  = {1'b0, blk_reg} ^ (CW'(1) << ord_reg);
    assign bud       = bud_wide[SW-1:0];
    assign found_top = top_reg[found];
    assign top_push  = top_reg[push_ord];
    assign push_size = CW'(1) << push_ord;
    assign ord_size  = CW'(1) << ord_reg;
    assign p_valid   = prev_q < bpa_pkg::NONE_SLOT;
    assign n_valid   = next_q < bpa_pkg::NONE_SLOT;

    // ceil(log2(count)), largest carve order, lowest usable order
    always_comb
    begin
        need_c    = '0;
        carve_ord = '0;
        hit       = 1'b0;
        found     = '0;
        for (int k = 0; k < CW; k++)
        begin
            if (({1'b0, CW'(1)} << k) < {1'b0, cnt_reg})
            begin
                need_c = OW'(k + 1);
            end
        end
        for (int k = 0; k < MO; k++)
        begin
            if (remain_reg >= (CW'(1) << k))
            begin
                carve_ord = OW'(k);
            end
        end
        for (int k = MO - 1; k >= 0; k--)
        begin
            if ((OW'(k) >= need_c) && (top_reg[k] != bpa_pkg::NONE_SLOT))
            begin
                hit   = 1'b1;
                found = OW'(k);
            end
        end
    end

    always_comb
    begin
        push_active = 1'b1;
        push_idx    = blk_reg;
        push_ord    = ord_reg;
        unique case (op)
            bpa_pkg::OP_CARVE_PUSH:
            begin
                push_idx = pos_reg[SW-1:0];
                push_ord = carve_ord;
            end
            bpa_pkg::OP_FREE_PUSH:
            begin
                push_idx = idx_reg[SW-1:0];
                push_ord = '0;
            end
            bpa_pkg::OP_MERGE_PUSH:
            begin
                push_idx = blk_reg & ~(SW'(1) << ord_reg);
                push_ord = ord_reg + OW'(1);
            end
            bpa_pkg::OP_SPLIT_PUSH:
            begin
                push_idx = blk_reg + (SW'(1) << (ord_reg - OW'(1)));
                push_ord = ord_reg - OW'(1);
            end
            default:
            begin
                push_active = 1'b0;
            end
        endcase
    end

    // RAM port steering
    always_comb
    begin
        mark_we     = 1'b0;
        mark_waddr  = push_idx;
        mark_wdata  = 1'b1;
        order_we    = push_active;
        order_waddr = push_idx;
        order_wdata = push_ord;
        next_we     = push_active;
        next_waddr  = push_idx;
        next_wdata  = top_push;
        prev_we     = push_active;
        prev_waddr  = push_idx;
        prev_wdata  = bpa_pkg::NONE_SLOT;
        mark_raddr  = (op == bpa_pkg::OP_FREE_RD) ? idx_reg[SW-1:0] : bud;
        link_raddr  = bud;

        if (push_active)
        begin
            mark_we = 1'b1;
        end
        if (op == bpa_pkg::OP_CLR_STEP)
        begin
            mark_we    = 1'b1;
            mark_waddr = clr_addr_reg;
            mark_wdata = 1'b0;
        end
        if (op == bpa_pkg::OP_UNLINK_WR)
        begin
            mark_we    = 1'b1;
            mark_waddr = uidx_reg;
            mark_wdata = 1'b0;
            next_we    = p_valid;
            next_waddr = prev_q[SW-1:0];
            next_wdata = next_q;
            prev_we    = n_valid;
            prev_waddr = next_q[SW-1:0];
            prev_wdata = prev_q;
        end
        if (op == bpa_pkg::OP_PUSH2)
        begin
            prev_we    = old_reg < bpa_pkg::NONE_SLOT;
            prev_waddr = old_reg[SW-1:0];
            prev_wdata = {1'b0, pidx_reg};
        end
        if (op == bpa_pkg::OP_ALLOC_FIN)
        begin
            order_we    = 1'b1;
            order_waddr = blk_reg;
            order_wdata = need_reg;
        end
        if (op == bpa_pkg::OP_UNL_RD_BLK)
        begin
            link_raddr = blk_reg;
        end
        if (op == bpa_pkg::OP_ALLOC_TAKE)
        begin
            link_raddr = found_top[SW-1:0];
        end
    end

    bpa_ram #(.WIDTH(1), .DEPTH(bpa_pkg::PAGE_SLOTS)) u_mark (
        .clk   (clk),
        .we    (mark_we),
        .waddr (mark_waddr),
        .wdata (mark_wdata),
        .raddr (mark_raddr),
        .rdata (mark_q)
    );

    bpa_ram #(.WIDTH(OW), .DEPTH(bpa_pkg::PAGE_SLOTS)) u_order (
        .clk   (clk),
        .we    (order_we),
        .waddr (order_waddr),
        .wdata (order_wdata),
        .raddr (bud),
        .rdata (order_q)
    );

    bpa_ram #(.WIDTH(LW), .DEPTH(bpa_pkg::PAGE_SLOTS)) u_next (
        .clk   (clk),
        .we    (next_we),
        .waddr (next_waddr),
        .wdata (next_wdata),
        .raddr (link_raddr),
        .rdata (next_q)
    );

    bpa_ram #(.WIDTH(LW), .DEPTH(bpa_pkg::PAGE_SLOTS)) u_prev (
        .clk   (clk),
        .we    (prev_we),
        .waddr (prev_waddr),
        .wdata (prev_wdata),
        .raddr (link_raddr),
        .rdata (prev_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            managed_reg  <= CW'(bpa_pkg::PAGE_SLOTS);
            clr_addr_reg <= '0;
            total_reg    <= '0;
            for (int k = 0; k < MO; k++)
            begin
                top_reg[k] <= bpa_pkg::NONE_SLOT;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                managed_reg <= cfg_wdata;
            end
            if (op == bpa_pkg::OP_CLR_STEP)
            begin
                clr_addr_reg <= clr_addr_reg + SW'(1);
            end
            if (op == bpa_pkg::OP_CLR_START)
            begin
                total_reg <= '0;
                for (int k = 0; k < MO; k++)
                begin
                    top_reg[k] <= bpa_pkg::NONE_SLOT;
                end
            end
            if (push_active)
            begin
                top_reg[push_ord] <= {1'b0, push_idx};
                total_reg         <= total_reg + push_size;
            end
            if (op == bpa_pkg::OP_UNLINK_WR)
            begin
                if (!p_valid)
                begin
                    top_reg[ord_reg] <= next_q;
                end
                total_reg <= total_reg - ord_size;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_active)
        begin
            pidx_reg <= push_idx;
            old_reg  <= top_push;
        end
        unique case (op)
            bpa_pkg::OP_LATCH:
            begin
                idx_reg    <= {2'b00, req.page_index};
                cnt_reg    <= req.page_count;
                ok_reg     <= 1'b1;
                bidx_reg   <= '0;
                bord_reg   <= '0;
                pos_reg    <= '0;
                remain_reg <= range_end;
            end
            bpa_pkg::OP_CARVE_PUSH:
            begin
                pos_reg    <= pos_reg + push_size;
                remain_reg <= remain_reg - push_size;
            end
            bpa_pkg::OP_FREE_SKIP:
            begin
                ok_reg  <= 1'b0;
                idx_reg <= idx_reg + bpa_pkg::CUR_W'(1);
                cnt_reg <= cnt_reg - CW'(1);
            end
            bpa_pkg::OP_FREE_PUSH:
            begin
                blk_reg <= push_idx;
                ord_reg <= '0;
                idx_reg <= idx_reg + bpa_pkg::CUR_W'(1);
                cnt_reg <= cnt_reg - CW'(1);
            end
            bpa_pkg::OP_UNL_RD_BUD:
            begin
                uidx_reg <= bud;
            end
            bpa_pkg::OP_UNL_RD_BLK:
            begin
                uidx_reg <= blk_reg;
            end
            bpa_pkg::OP_MERGE_PUSH:
            begin
                blk_reg <= push_idx;
                ord_reg <= push_ord;
            end
            bpa_pkg::OP_ALLOC_TAKE:
            begin
                uidx_reg <= found_top[SW-1:0];
                blk_reg  <= found_top[SW-1:0];
                ord_reg  <= found;
                need_reg <= need_c;
            end
            bpa_pkg::OP_SPLIT_PUSH:
            begin
                ord_reg <= push_ord;
            end
            bpa_pkg::OP_ALLOC_FIN:
            begin
                bidx_reg <= blk_reg;
                bord_reg <= need_reg;
            end
            bpa_pkg::OP_FAIL:
            begin
                ok_reg <= 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        status.idx_in_range = idx_reg < {1'b0, range_end};
        status.mark_set     = mark_q;
        status.bud_avail    = (ord_reg < OW'(MO - 1)) && (bud_wide < range_end);
        status.bud_match    = mark_q && (order_q == ord_reg);
        status.alloc_ok     = (cnt_reg != '0) && (cnt_reg <= total_reg) && hit;
        status.split_more   = ord_reg > need_reg;
        status.cnt_zero     = cnt_reg == '0;
        status.remain_zero  = remain_reg == '0;
        status.clr_last     = &clr_addr_reg;
    end

    assign result.ok          = ok_reg;
    assign result.block_index = bidx_reg;
    assign result.block_order = bord_reg;
    assign result.free_total  = total_reg;

`ifndef SYNTHESIS
    a_push2_after_push: assert property (@(posedge clk) disable iff (!rst_n)
        (op == bpa_pkg::OP_PUSH2) |-> $past(push_active))
        else $error("second push phase without a first");

    a_unlink_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (op == bpa_pkg::OP_UNLINK_WR) |->
            ($past(op) == bpa_pkg::OP_UNL_RD_BUD || $past(op) == bpa_pkg::OP_UNL_RD_BLK
             || $past(op) == bpa_pkg::OP_ALLOC_TAKE))
        else $error("unlink write without link read");

    a_split_above_need: assert property (@(posedge clk) disable iff (!rst_n)
        (op == bpa_pkg::OP_SPLIT_PUSH) |-> (ord_reg > need_reg))
        else $error("split below requested order");
`endif

endmodule

[rtl/bpa_ctrl.sv]
module bpa_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [1:0]          req_type,
    input  bpa_pkg::dp_status_t status,
    output bpa_pkg::dp_op_t     op,
    output logic                busy,
    output logic                done
);

    typedef enum logic [4:0] {
        S_RST_CLR,
        S_IDLE,
        S_FAIL,
        S_DONE,
        S_INIT_START,
        S_INIT_CLR,
        S_CARVE,
        S_CARVE_P2,
        S_FREE,
        S_FREE_CHK,
        S_FREE_P2,
        S_MERGE,
        S_MERGE_CHK,
        S_UNL_BUD,
        S_UNL_BLK_RD,
        S_UNL_BLK,
        S_MERGE_PUSH,
        S_MERGE_P2,
        S_ALLOC,
        S_ALLOC_UNL,
        S_SPLIT,
        S_SPLIT_P2
    } state_t;

    state_t state_reg, state_next;
    logic   done_reg, done_next;

    always_comb
    begin
        state_next = state_reg;
        op         = bpa_pkg::OP_NONE;
        done_next  = 1'b0;
        unique case (state_reg)
            S_RST_CLR:
            begin
                op = bpa_pkg::OP_CLR_STEP;
                if (status.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    op = bpa_pkg::OP_LATCH;
                    unique case (req_type)
                        bpa_pkg::REQ_INIT:  state_next = S_INIT_START;
                        bpa_pkg::REQ_ALLOC: state_next = S_ALLOC;
                        bpa_pkg::REQ_FREE:  state_next = S_FREE;
                        default:            state_next = S_FAIL;
                    endcase
                end
            end
            S_FAIL:
            begin
                op         = bpa_pkg::OP_FAIL;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            S_INIT_START:
            begin
                op         = bpa_pkg::OP_CLR_START;
                state_next = S_INIT_CLR;
            end
            S_INIT_CLR:
            begin
                op = bpa_pkg::OP_CLR_STEP;
                if (status.clr_last)
                begin
                    state_next = S_CARVE;
                end
            end
            S_CARVE:
            begin
                if (status.remain_zero)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    op         = bpa_pkg::OP_CARVE_PUSH;
                    state_next = S_CARVE_P2;
                end
            end
            S_CARVE_P2:
            begin
                op         = bpa_pkg::OP_PUSH2;
                state_next = S_CARVE;
            end
            S_FREE:
            begin
                priority if (status.cnt_zero)
                begin
                    state_next = S_DONE;
                end
                else if (!status.idx_in_range)
                begin
                    op = bpa_pkg::OP_FREE_SKIP;
                end
                else
                begin
                    op         = bpa_pkg::OP_FREE_RD;
                    state_next = S_FREE_CHK;
                end
            end
            S_FREE_CHK:
            begin
                if (status.mark_set)
                begin
                    op         = bpa_pkg::OP_FREE_SKIP;
                    state_next = S_FREE;
                end
                else
                begin
                    op         = bpa_pkg::OP_FREE_PUSH;
                    state_next = S_FREE_P2;
                end
            end
            S_FREE_P2:
            begin
                op         = bpa_pkg::OP_PUSH2;
                state_next = S_MERGE;
            end
            S_MERGE:
            begin
                if (status.bud_avail)
                begin
                    op         = bpa_pkg::OP_BUD_RD;
                    state_next = S_MERGE_CHK;
                end
                else
                begin
                    state_next = S_FREE;
                end
            end
            S_MERGE_CHK:
            begin
                if (status.bud_match)
                begin
                    op         = bpa_pkg::OP_UNL_RD_BUD;
                    state_next = S_UNL_BUD;
                end
                else
                begin
                    state_next = S_FREE;
                end
            end
            S_UNL_BUD:
            begin
                op         = bpa_pkg::OP_UNLINK_WR;
                state_next = S_UNL_BLK_RD;
            end
            S_UNL_BLK_RD:
            begin
                op         = bpa_pkg::OP_UNL_RD_BLK;
                state_next = S_UNL_BLK;
            end
            S_UNL_BLK:
            begin
                op         = bpa_pkg::OP_UNLINK_WR;
                state_next = S_MERGE_PUSH;
            end
            S_MERGE_PUSH:
            begin
                op         = bpa_pkg::OP_MERGE_PUSH;
                state_next = S_MERGE_P2;
            end
            S_MERGE_P2:
            begin
                op         = bpa_pkg::OP_PUSH2;
                state_next = S_MERGE;
            end
            S_ALLOC:
            begin
                if (status.alloc_ok)
                begin
                    op         = bpa_pkg::OP_ALLOC_TAKE;
                    state_next = S_ALLOC_UNL;
                end
                else
                begin
                    op         = bpa_pkg::OP_FAIL;
                    state_next = S_DONE;
                end
            end
            S_ALLOC_UNL:
            begin
                op         = bpa_pkg::OP_UNLINK_WR;
                state_next = S_SPLIT;
            end
            S_SPLIT:
            begin
                if (status.split_more)
                begin
                    op         = bpa_pkg::OP_SPLIT_PUSH;
                    state_next = S_SPLIT_P2;
                end
                else
                begin
                    op         = bpa_pkg::OP_ALLOC_FIN;
                    state_next = S_DONE;
                end
            end
            S_SPLIT_P2:
            begin
                op         = bpa_pkg::OP_PUSH2;
                state_next = S_SPLIT;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_RST_CLR;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy = state_reg != S_IDLE;
    assign done = done_reg;

endmodule

[rtl/buddy_page_allocator.sv]
// Buddy page allocator, command style.
// Request: drive req and raise start; the transaction is taken on the clock
// edge where start is high and busy is low. req_type selects init (carve the
// managed range into power-of-two blocks), allocate (page_count rounded up to
// an order) or free (page_count pages from page_index, one page at a time,
// merging with buddies).
// Result: done pulses for exactly one cycle with result valid; the receiver
// must take it then, as it cannot hold the block off. done comes in a cycle
// where busy is already low, so the next request may start in that cycle.
// Configuration: cfg_we writes cfg_wdata into managed_pages; only write while
// idle.
// Transactions run one at a time (shared list RAMs). Init clears the mark
// RAM one slot a cycle, then pushes each carved block in two phases.
// Allocate fails at once, or takes and unlinks a block, pushes one half per
// split level and records the order. Free skips each page that is out of
// range or already free, else pushes it, then per merge level reads and
// checks the buddy, unlinks both blocks and pushes the merged one. An
// unknown request type fails. After reset busy stays high while the free-head
// marks are cleared; configuration writes are still accepted then.
module buddy_page_allocator (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  bpa_pkg::req_t     req,
    output logic              done,
    output bpa_pkg::result_t  result,
    input  logic              cfg_we,
    input  logic [12:0]       cfg_wdata
);

    bpa_pkg::dp_op_t     op;
    bpa_pkg::dp_status_t status;

    // sequencer: walks lists, splits and merges one step a cycle
    bpa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (req.req_type),
        .status   (status),
        .op       (op),
        .busy     (busy),
        .done     (done)
    );

    // list RAMs, per-order heads and free total
    bpa_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (op),
        .req       (req),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .status    (status),
        .result    (result)
    );

`ifndef SYNTHESIS
    a_start_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("transaction taken but block not busy");

    a_done_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    a_done_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without a transaction in flight");
`endif

endmodule
